### hdl/amc_pkg.sv
// shared constants, types and helpers for the adjacency matrix connectivity unit
`timescale 1ns / 1ps

package amc_pkg;

	localparam int MAX_VERTICES = 16;
	localparam int VTX_W        = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
	localparam int ADDR_W       = 2 * VTX_W;
	localparam int DEPTH        = MAX_VERTICES * MAX_VERTICES;
	localparam int WEIGHT_W     = 32;
	localparam int IDX_W        = 4;
	localparam int CMD_W        = 2;
	localparam int CFG_W        = 5;
	localparam logic [CFG_W-1:0] VCOUNT_RESET = CFG_W'(16);

	typedef enum logic [CMD_W-1:0] {
		CMD_WRITE = 2'd0,
		CMD_READ  = 2'd1,
		CMD_QUERY = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WR2,
		ST_RD,
		ST_QRY
	} state_t;

	typedef struct packed {
		logic [CMD_W-1:0]           command;
		logic [IDX_W-1:0]           row;
		logic [IDX_W-1:0]           col;
		logic signed [WEIGHT_W-1:0] write_value;
	} request_t;

	typedef struct packed {
		logic signed [WEIGHT_W-1:0] read_value;
		logic                       connected;
		logic                       out_of_range;
	} result_t;

	typedef struct packed {
		logic done;
		logic connected;
	} srch_stat_t;

	function automatic logic [CNT_W-1:0] eff_count(input logic [CFG_W-1:0] v);
		logic [CNT_W-1:0] n;
		if (v == '0) begin
			n = CNT_W'(1);
		end else if (32'(v) > MAX_VERTICES) begin
			n = CNT_W'(MAX_VERTICES);
		end else begin
			n = CNT_W'(v);
		end
		return n;
	endfunction

endpackage

### hdl/adjacency_matrix_connectivity_unit.sv
// top level: weighted adjacency matrix with write, read and connectivity query
`timescale 1ns / 1ps

// channel   direction  handshake                 payload
// request   in         start, busy               request (request_t)
// result    out        done, one-cycle strobe    result (result_t)
// config    in         cfg_valid, cfg_ready      cfg_data (vertex count)
//
// out of range access or unused command: answered from idle; read passes through ST_RD, write through ST_WR2
// query: at most n passes of the search unit, n the vertex count in use,
//   one matrix row per cycle
// reset clears the edge presence flops at once; no clearing pass
// the result strobe cannot be stalled; the next request may enter while it shows, except after an in-range write

module adjacency_matrix_connectivity_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  amc_pkg::request_t           request,
	output logic                        done,
	output amc_pkg::result_t            result,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [amc_pkg::CFG_W-1:0]   cfg_data
);

	amc_pkg::state_t                   state_q;
	amc_pkg::state_t                   state_n;
	amc_pkg::request_t                 req_q;
	amc_pkg::result_t                  res_q;
	amc_pkg::srch_stat_t               stat;
	logic [amc_pkg::CFG_W-1:0]         vcount_q;
	logic [amc_pkg::CNT_W-1:0]         ncnt;
	logic [amc_pkg::MAX_VERTICES-1:0]  nz_q [amc_pkg::MAX_VERTICES];
	logic [amc_pkg::VTX_W-1:0]         r_idx;
	logic [amc_pkg::VTX_W-1:0]         c_idx;
	logic [amc_pkg::VTX_W-1:0]         vtx;
	logic [amc_pkg::ADDR_W-1:0]        ram_addr;
	logic [amc_pkg::WEIGHT_W-1:0]      ram_rdata;
	logic                              ram_we;
	logic                              accept;
	logic                              oor;
	logic                              go;
	logic                              nzbit_q;
	logic                              done_q;
	amc_pkg::cmd_t                     cmd;

	assign accept    = start && (state_q == amc_pkg::ST_IDLE);
	assign busy      = (state_q != amc_pkg::ST_IDLE);
	assign cfg_ready = 1'b1;
	assign ncnt      = amc_pkg::eff_count(vcount_q);
	assign cmd       = amc_pkg::cmd_t'(request.command);
	assign r_idx     = amc_pkg::VTX_W'(request.row);
	assign c_idx     = amc_pkg::VTX_W'(request.col);
	assign oor       = (32'(request.row) >= 32'(ncnt)) || (32'(request.col) >= 32'(ncnt));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= amc_pkg::VCOUNT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			vcount_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= amc_pkg::ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n  = state_q;
		ram_we   = 1'b0;
		ram_addr = {r_idx, c_idx};
		go       = 1'b0;
		case (state_q)
			amc_pkg::ST_IDLE: begin
				if (accept && !oor && (cmd == amc_pkg::CMD_WRITE)) begin
					ram_we  = 1'b1;
					state_n = amc_pkg::ST_WR2;
				end else if (accept && !oor && (cmd == amc_pkg::CMD_READ)) begin
					state_n = amc_pkg::ST_RD;
				end else if (accept && (cmd == amc_pkg::CMD_QUERY)) begin
					go      = 1'b1;
					state_n = amc_pkg::ST_QRY;
				end
			end
			amc_pkg::ST_WR2: begin
				ram_we   = 1'b1;
				ram_addr = {amc_pkg::VTX_W'(req_q.col), amc_pkg::VTX_W'(req_q.row)};
				state_n  = amc_pkg::ST_IDLE;
			end
			amc_pkg::ST_RD: begin
				state_n = amc_pkg::ST_IDLE;
			end
			amc_pkg::ST_QRY: begin
				if (stat.done) begin
					state_n = amc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_n = amc_pkg::ST_IDLE;
			end
		endcase
	end

	// edge presence flags, also stand in as valid bits for the weight ram
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < amc_pkg::MAX_VERTICES; i++) begin
				nz_q[i] <= '0;
			end
		end else if (accept && !oor && (cmd == amc_pkg::CMD_WRITE)) begin
			nz_q[r_idx][c_idx] <= |request.write_value;
			nz_q[c_idx][r_idx] <= |request.write_value;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q   <= request;
			nzbit_q <= nz_q[r_idx][c_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (accept && (cmd != amc_pkg::CMD_READ || oor)
				&& (cmd != amc_pkg::CMD_QUERY))
				|| (state_q == amc_pkg::ST_RD)
				|| (state_q == amc_pkg::ST_QRY && stat.done);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q.read_value   <= '0;
			res_q.connected    <= 1'b0;
			res_q.out_of_range <= oor && (cmd == amc_pkg::CMD_WRITE || cmd == amc_pkg::CMD_READ);
		end else if (state_q == amc_pkg::ST_RD) begin
			res_q.read_value <= nzbit_q ? $signed(ram_rdata) : '0;
		end else if (state_q == amc_pkg::ST_QRY && stat.done) begin
			res_q.connected <= stat.connected;
		end
	end

	amc_ram #(
		.WIDTH (amc_pkg::WEIGHT_W),
		.DEPTH (amc_pkg::DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (state_q == amc_pkg::ST_WR2 ? req_q.write_value : request.write_value),
		.rdata (ram_rdata)
	);

	amc_search u_search (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (go),
		.n        (ncnt),
		.row_bits (nz_q[vtx]),
		.vtx      (vtx),
		.stat     (stat)
	);

	assign done   = done_q;
	assign result = res_q;

`ifndef SYNTHESIS
	a_query_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == amc_pkg::ST_QRY && stat.done) |=> (done && state_q == amc_pkg::ST_IDLE))
		else $error("query finish not reported");

	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(result.connected && result.out_of_range))
		else $error("connected and out of range both set");

	a_read_src: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.read_value != 0) |-> $past(state_q == amc_pkg::ST_RD))
		else $error("nonzero read value outside a read");

	a_wr2_once: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == amc_pkg::ST_WR2) |=> (state_q == amc_pkg::ST_IDLE))
		else $error("mirror write held too long");
`endif

endmodule

### hdl/amc_ram.sv
// generic single port ram with registered read
`timescale 1ns / 1ps

module amc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

### hdl/amc_search.sv
// iterative reachability search, one vertex row per cycle
`timescale 1ns / 1ps

module amc_search (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              go,
	input  logic [amc_pkg::CNT_W-1:0]         n,
	input  logic [amc_pkg::MAX_VERTICES-1:0]  row_bits,
	output logic [amc_pkg::VTX_W-1:0]         vtx,
	output amc_pkg::srch_stat_t               stat
);

	logic [amc_pkg::MAX_VERTICES-1:0] visited_q;
	logic [amc_pkg::MAX_VERTICES-1:0] mask;
	logic [amc_pkg::MAX_VERTICES-1:0] add;
	logic [amc_pkg::MAX_VERTICES-1:0] visited_n;
	logic [amc_pkg::VTX_W-1:0]        vtx_q;
	logic [amc_pkg::CNT_W-1:0]        pass_q;
	logic [amc_pkg::CNT_W-1:0]        pass_n;
	logic                             grew_q;
	logic                             grew_n;
	logic                             active_q;
	logic                             last_vtx;
	logic                             finish;
	logic                             done_q;
	logic                             conn_q;

	always_comb begin
		for (int i = 0; i < amc_pkg::MAX_VERTICES; i++) begin
			mask[i] = (32'(i) < 32'(n));
		end
		add       = visited_q[vtx_q] ? (row_bits & mask & ~visited_q) : '0;
		visited_n = visited_q | add;
		grew_n    = grew_q | (|add);
		last_vtx  = ((amc_pkg::CNT_W'(vtx_q) + amc_pkg::CNT_W'(1)) == n);
		pass_n    = pass_q + amc_pkg::CNT_W'(1);
		finish    = active_q && last_vtx && (!grew_n || (pass_n == n));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			visited_q <= '0;
			vtx_q     <= '0;
			pass_q    <= '0;
			grew_q    <= 1'b0;
			active_q  <= 1'b0;
			done_q    <= 1'b0;
			conn_q    <= 1'b0;
		end else begin
			done_q <= finish && !go;
			if (go) begin
				visited_q <= amc_pkg::MAX_VERTICES'(1);
				vtx_q     <= '0;
				pass_q    <= '0;
				grew_q    <= 1'b0;
				active_q  <= 1'b1;
			end else if (active_q) begin
				visited_q <= visited_n;
				if (finish) begin
					active_q <= 1'b0;
					conn_q   <= &(visited_n | ~mask);
				end else if (last_vtx) begin
					vtx_q  <= '0;
					pass_q <= pass_n;
					grew_q <= 1'b0;
				end else begin
					vtx_q  <= vtx_q + amc_pkg::VTX_W'(1);
					grew_q <= grew_n;
				end
			end
		end
	end

	assign vtx            = vtx_q;
	assign stat.done      = done_q;
	assign stat.connected = conn_q;

endmodule

### tb/sv/adjacency_matrix_connectivity_unit_test.sv
// testbench for the adjacency matrix connectivity unit: directed table, then random requests
`timescale 1ns / 1ps

module adjacency_matrix_connectivity_unit_test;
	import amc_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int QUIET_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 300;
	localparam int RANDOM_PHASES = 11;
	localparam int PHASE_ITEMS = 50;

	typedef struct {
		logic             is_cfg;
		logic [CFG_W-1:0] cfg_value;
		request_t         item;
		logic             typed;
		result_t          res;
	} step_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	request_t request = '0;
	logic done;
	result_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_W-1:0] cfg_data = '0;

	logic typed_check = 1'b0;
	result_t typed_result = '0;

	logic [WEIGHT_W-1:0] weight_mem [MAX_VERTICES][MAX_VERTICES];
	logic [MAX_VERTICES-1:0] reach_marks;
	logic [CFG_W-1:0] vtx_count;
	result_t pending_results[$];
	int errors = 0;
	int quiet_cycles = 0;

	adjacency_matrix_connectivity_unit i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.request(request),
		.done(done),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	function automatic int used_vertices();
		int n;
		n = int'(vtx_count);
		if (n == 0) begin
			n = 1;
		end else if (n > MAX_VERTICES) begin
			n = MAX_VERTICES;
		end
		return n;
	endfunction

	function automatic logic reach_all(int n);
		logic grew;
		logic all_seen;
		reach_marks = '0;
		reach_marks[0] = 1'b1;
		for (int pass = 0; pass < n; pass++) begin
			grew = 1'b0;
			for (int v = 0; v < n; v++) begin
				if (reach_marks[v]) begin
					for (int u = 0; u < n; u++) begin
						if (!reach_marks[u] && weight_mem[v][u] != '0) begin
							reach_marks[u] = 1'b1;
							grew = 1'b1;
						end
					end
				end
			end
			if (!grew) begin
				break;
			end
		end
		all_seen = 1'b1;
		for (int v = 0; v < n; v++) begin
			if (!reach_marks[v]) begin
				all_seen = 1'b0;
			end
		end
		return all_seen;
	endfunction

	function automatic result_t apply_request(request_t item);
		result_t res;
		int n;
		res = '0;
		n = used_vertices();
		if (item.command == CMD_WRITE || item.command == CMD_READ) begin
			if (int'(item.row) >= n || int'(item.col) >= n) begin
				res.out_of_range = 1'b1;
			end else if (item.command == CMD_WRITE) begin
				weight_mem[item.row][item.col] = item.write_value;
				weight_mem[item.col][item.row] = item.write_value;
			end else begin
				res.read_value = weight_mem[item.row][item.col];
			end
		end else if (item.command == CMD_QUERY) begin
			res.connected = reach_all(n);
		end
		return res;
	endfunction

	function automatic void compare_result(result_t want, result_t got);
		if (got.read_value !== want.read_value) begin
			$display("%0t: read_value expected %h, got %h", $time, want.read_value,
				got.read_value);
			errors++;
		end
		if (got.connected !== want.connected) begin
			$display("%0t: connected expected %b, got %b", $time, want.connected,
				got.connected);
			errors++;
		end
		if (got.out_of_range !== want.out_of_range) begin
			$display("%0t: out_of_range expected %b, got %b", $time, want.out_of_range,
				got.out_of_range);
			errors++;
		end
	endfunction

	always @(posedge clk) begin
		result_t want;
		logic moved;
		moved = 1'b0;
		if (arst_n) begin
			if (done) begin
				moved = 1'b1;
				if (pending_results.size() == 0) begin
					$display("%0t: result with none expected, got %h %b %b", $time,
						result.read_value, result.connected, result.out_of_range);
					errors++;
				end else begin
					want = pending_results.pop_front();
					compare_result(want, result);
				end
			end
			if (start && !busy) begin
				moved = 1'b1;
				want = apply_request(request);
				if (typed_check) begin
					want = typed_result;
				end
				pending_results.push_back(want);
			end
			if (cfg_valid && cfg_ready) begin
				moved = 1'b1;
				vtx_count = cfg_data;
			end
		end
		quiet_cycles = moved ? 0 : quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("adjacency_matrix_connectivity_unit test failed");
			$finish;
		end
	end

	function automatic step_row_t req_row(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] r,
		logic [IDX_W-1:0] c, logic [WEIGHT_W-1:0] wv, logic typed,
		logic [WEIGHT_W-1:0] rd, logic conn, logic oor);
		step_row_t s;
		s.is_cfg = 1'b0;
		s.cfg_value = '0;
		s.item.command = cmd;
		s.item.row = r;
		s.item.col = c;
		s.item.write_value = wv;
		s.typed = typed;
		s.res.read_value = rd;
		s.res.connected = conn;
		s.res.out_of_range = oor;
		return s;
	endfunction

	function automatic step_row_t cfg_row(logic [CFG_W-1:0] v);
		step_row_t s;
		s = req_row(CMD_UNUSED, '0, '0, '0, 1'b0, '0, 1'b0, 1'b0);
		s.is_cfg = 1'b1;
		s.cfg_value = v;
		return s;
	endfunction

	function automatic request_t random_request(int n);
		request_t item;
		int r;
		r = $urandom_range(99, 0);
		item.command = (r < 45) ? CMD_WRITE : (r < 75) ? CMD_READ :
			(r < 95) ? CMD_QUERY : CMD_UNUSED;
		if ($urandom_range(99, 0) < 85) begin
			item.row = IDX_W'($urandom_range(n - 1, 0));
			item.col = IDX_W'($urandom_range(n - 1, 0));
		end else begin
			item.row = IDX_W'($urandom_range(15, 0));
			item.col = IDX_W'($urandom_range(15, 0));
		end
		r = $urandom_range(99, 0);
		if (r < 30) begin
			item.write_value = '0;
		end else if (r < 45) begin
			case ($urandom_range(3, 0))
				0: item.write_value = 32'h0000_0001;
				1: item.write_value = 32'hFFFF_FFFF;
				2: item.write_value = 32'h8000_0000;
				default: item.write_value = 32'h7FFF_FFFF;
			endcase
		end else begin
			item.write_value = $urandom;
		end
		return item;
	endfunction

	function automatic int gap_length();
		int r;
		r = $urandom_range(99, 0);
		if (r < 65) begin
			return 0;
		end else if (r < 93) begin
			return $urandom_range(3, 1);
		end
		return $urandom_range(40, 8);
	endfunction

	task automatic send_request(input request_t item, input logic chk, input result_t res);
		start <= 1'b1;
		request <= item;
		typed_check <= chk;
		typed_result <= res;
		@(posedge clk);
		while (busy) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic idle_for(input int n);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(negedge clk);
		end
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0 || busy) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_count(input logic [CFG_W-1:0] v);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		step_row_t rows[$];
		logic [CFG_W-1:0] phase_count;
		int pause_at;
		int n;
		for (int i = 0; i < MAX_VERTICES; i++) begin
			for (int j = 0; j < MAX_VERTICES; j++) begin
				weight_mem[i][j] = '0;
			end
		end
		reach_marks = '0;
		vtx_count = VCOUNT_RESET;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty matrix, full vertex count
		rows.push_back(req_row(CMD_READ, 0, 0, '0, 1, 32'h0, 0, 0));
		rows.push_back(req_row(CMD_READ, 15, 15, '0, 1, 32'h0, 0, 0));
		rows.push_back(req_row(CMD_QUERY, 0, 0, '0, 1, 32'h0, 0, 0));
		rows.push_back(req_row(CMD_UNUSED, 15, 15, 32'hFFFF_FFFF, 1, 32'h0, 0, 0));
		// extremes of weight and index, symmetric store
		rows.push_back(req_row(CMD_WRITE, 0, 15, 32'h7FFF_FFFF, 1, 32'h0, 0, 0));
		rows.push_back(req_row(CMD_READ, 15, 0, '0, 1, 32'h7FFF_FFFF, 0, 0));
		rows.push_back(req_row(CMD_WRITE, 3, 3, 32'h8000_0000, 1, 32'h0, 0, 0));
		rows.push_back(req_row(CMD_READ, 3, 3, '0, 1, 32'h8000_0000, 0, 0));
		rows.push_back(req_row(CMD_WRITE, 1, 2, 32'hFFFF_FFFF, 1, 32'h0, 0, 0));
		rows.push_back(req_row(CMD_READ, 2, 1, '0, 1, 32'hFFFF_FFFF, 0, 0));
		// query ignores its operands
		rows.push_back(req_row(CMD_QUERY, 15, 9, 32'h1234_5678, 0, '0, 0, 0));
		rows.push_back(req_row(CMD_WRITE, 0, 15, 32'h0, 1, 32'h0, 0, 0));
		rows.push_back(req_row(CMD_READ, 0, 15, '0, 1, 32'h0, 0, 0));
		// reduced count: indices out of range, weights kept
		rows.push_back(cfg_row(4));
		rows.push_back(req_row(CMD_WRITE, 4, 0, 32'h1, 1, 32'h0, 0, 1));
		rows.push_back(req_row(CMD_READ, 0, 4, '0, 1, 32'h0, 0, 1));
		rows.push_back(req_row(CMD_READ, 15, 15, '0, 1, 32'h0, 0, 1));
		rows.push_back(req_row(CMD_WRITE, 0, 1, 32'h5, 0, '0, 0, 0));
		rows.push_back(req_row(CMD_WRITE, 2, 3, 32'h7, 0, '0, 0, 0));
		rows.push_back(req_row(CMD_QUERY, 0, 0, '0, 0, '0, 0, 0));
		rows.push_back(req_row(CMD_READ, 2, 1, '0, 0, '0, 0, 0));
		// count zero acts as one vertex
		rows.push_back(cfg_row(0));
		rows.push_back(req_row(CMD_QUERY, 0, 0, '0, 1, 32'h0, 1, 0));
		rows.push_back(req_row(CMD_READ, 0, 1, '0, 1, 32'h0, 0, 1));
		rows.push_back(req_row(CMD_WRITE, 0, 0, 32'hAAAA_5555, 0, '0, 0, 0));
		// count above the maximum saturates
		rows.push_back(cfg_row(31));
		rows.push_back(req_row(CMD_QUERY, 0, 0, '0, 0, '0, 0, 0));
		rows.push_back(req_row(CMD_READ, 15, 15, '0, 0, '0, 0, 0));
		rows.push_back(cfg_row(16));

		foreach (rows[i]) begin
			if (rows[i].is_cfg) begin
				write_count(rows[i].cfg_value);
			end else begin
				send_request(rows[i].item, rows[i].typed, rows[i].res);
				idle_for(gap_length());
			end
		end

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			case (ph)
				0: phase_count = 1;
				1: phase_count = 2;
				2: phase_count = 16;
				3: phase_count = 31;
				4: phase_count = 0;
				default: phase_count = CFG_W'($urandom_range(16, 1));
			endcase
			write_count(phase_count);
			n = used_vertices();
			pause_at = $urandom_range(PHASE_ITEMS - 1, 10);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if (k == pause_at) begin
					wait_drained();
				end
				send_request(random_request(n), 1'b0, '0);
				if (ph % 3 != 2) begin
					idle_for(gap_length());
				end
			end
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("adjacency_matrix_connectivity_unit test passed");
		end else begin
			$display("adjacency_matrix_connectivity_unit test failed");
		end
		$finish;
	end

endmodule

### adjacency_matrix_connectivity_unit.f
hdl/amc_pkg.sv
hdl/amc_ram.sv
hdl/amc_search.sv
hdl/adjacency_matrix_connectivity_unit.sv
tb/sv/adjacency_matrix_connectivity_unit_test.sv
